@@ sv/bscc_pkg.sv @@
// Shared constants for the bend sensor calibrate/classify block.
`default_nettype none

package bscc_pkg;

    localparam int SAMPLE_BITS_DEF = 10;
    localparam int RISE_BITS       = 5;
    localparam int CODE_BITS       = 4;
    localparam int PHASE_BITS      = 2;

    localparam logic [RISE_BITS-1:0] RISES_RESET = 5'd20;

    // item function
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_START  = 1'b1;

    // calibration phase
    localparam logic [PHASE_BITS-1:0] PH_RUN  = 2'd0;
    localparam logic [PHASE_BITS-1:0] PH_SEC0 = 2'd1;
    localparam logic [PHASE_BITS-1:0] PH_SEC1 = 2'd2;
    localparam logic [PHASE_BITS-1:0] PH_SEC2 = 2'd3;

    // bend codes
    localparam logic [CODE_BITS-1:0] BEND_NONE    = 4'd0;
    localparam logic [CODE_BITS-1:0] BEND_S0      = 4'd1;
    localparam logic [CODE_BITS-1:0] BEND_S1      = 4'd2;
    localparam logic [CODE_BITS-1:0] BEND_S0S1    = 4'd3;
    localparam logic [CODE_BITS-1:0] BEND_S2      = 4'd4;
    localparam logic [CODE_BITS-1:0] BEND_S0S2    = 4'd5;
    localparam logic [CODE_BITS-1:0] BEND_S1S2    = 4'd6;
    localparam logic [CODE_BITS-1:0] BEND_ALL     = 4'd7;
    localparam logic [CODE_BITS-1:0] BEND_NOT_CAL = 4'd8;
    localparam logic [CODE_BITS-1:0] BEND_CALIB   = 4'd9;

    // combination limit slots
    localparam logic [1:0] CMB_S0S1 = 2'd0;
    localparam logic [1:0] CMB_S0S2 = 2'd1;
    localparam logic [1:0] CMB_S1S2 = 2'd2;
    localparam logic [1:0] CMB_ALL  = 2'd3;

endpackage

`default_nettype wire

@@ sv/bscc_classify.sv @@
// Run-mode classifier: priority chain of half-open ranges over the limits.
`default_nettype none

module bscc_classify
    import bscc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic [SAMPLE_BITS-1:0]         i_sample,
    input  wire logic [SAMPLE_BITS-1:0]         i_sec0,
    input  wire logic [SAMPLE_BITS-1:0]         i_sec1,
    input  wire logic [SAMPLE_BITS-1:0]         i_sec2,
    input  wire logic [3:0][SAMPLE_BITS+1:0]    i_combo,
    output logic      [CODE_BITS-1:0]           o_code
);

    localparam int CW = SAMPLE_BITS + 2;

    logic [CW-1:0] s, l1, l2, l3, l4, l5, l6, l7;

    always_comb begin
        s  = CW'(i_sample);
        l1 = CW'(i_sec0);
        l2 = CW'(i_sec1);
        l3 = i_combo[CMB_S0S1];
        l4 = CW'(i_sec2);
        l5 = i_combo[CMB_S0S2];
        l6 = i_combo[CMB_S1S2];
        l7 = i_combo[CMB_ALL];

        if (l1 == '0 && l2 == '0 && l3 == '0 && l4 == '0 &&
            l5 == '0 && l6 == '0 && l7 == '0) begin
            o_code = BEND_NOT_CAL;
        end else if (s < l1) begin
            o_code = BEND_NONE;
        end else if (s < l2) begin
            o_code = BEND_S0;
        end else if (s >= l2 && s < l3) begin
            o_code = BEND_S1;
        end else if (s >= l3 && s < l4) begin
            o_code = BEND_S0S1;
        end else if (s >= l4 && s < l5) begin
            o_code = BEND_S2;
        end else if (s >= l5 && s < l6) begin
            o_code = BEND_S0S2;
        end else if (s >= l6 && s < l7) begin
            o_code = BEND_S1S2;
        end else if (s >= l7) begin
            o_code = BEND_ALL;
        end else begin
            // limits out of order, no range holds
            o_code = BEND_NOT_CAL;
        end
    end

endmodule

`default_nettype wire

@@ sv/bscc_calib.sv @@
// Calibration sequencer: phase, rise count, section and combination limits.
`default_nettype none

module bscc_calib
    import bscc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_step,
    input  wire logic                           i_func,
    input  wire logic [SAMPLE_BITS-1:0]         i_sample,
    input  wire logic [RISE_BITS-1:0]           i_rises_needed,
    output logic      [PHASE_BITS-1:0]          o_phase,
    output logic      [PHASE_BITS-1:0]          o_next_phase,
    output logic      [SAMPLE_BITS-1:0]         o_sec0,
    output logic      [SAMPLE_BITS-1:0]         o_sec1,
    output logic      [SAMPLE_BITS-1:0]         o_sec2,
    output logic      [3:0][SAMPLE_BITS+1:0]    o_combo
);

    localparam int CW = SAMPLE_BITS + 2;

    logic [PHASE_BITS-1:0]   r_phase, n_phase;
    logic [RISE_BITS-1:0]    r_rise, n_rise;
    logic [SAMPLE_BITS-1:0]  r_sec0, r_sec1, r_sec2;
    logic [SAMPLE_BITS-1:0]  n_sec0, n_sec1, n_sec2;
    logic [3:0][CW-1:0]      r_combo, n_combo;

    logic [SAMPLE_BITS-1:0]  own, below;
    logic                    rise_hit;
    logic [RISE_BITS-1:0]    rise_next;

    always_comb begin
        unique case (r_phase)
            PH_SEC0: begin
                own   = r_sec0;
                below = '0;
            end
            PH_SEC1: begin
                own   = r_sec1;
                below = r_sec0;
            end
            default: begin
                own   = r_sec2;
                below = r_sec1;
            end
        endcase

        rise_hit  = (i_sample > own) && (i_sample > below);
        rise_next = rise_hit ? r_rise + RISE_BITS'(1) : r_rise;

        n_phase = r_phase;
        n_rise  = r_rise;
        n_sec0  = r_sec0;
        n_sec1  = r_sec1;
        n_sec2  = r_sec2;
        n_combo = r_combo;

        if (i_step) begin
            if (i_func == FUNC_START) begin
                n_phase = PH_SEC0;
                n_rise  = '0;
            end else if (r_phase != PH_RUN) begin
                if (rise_hit) begin
                    unique case (r_phase)
                        PH_SEC0: n_sec0 = i_sample;
                        PH_SEC1: n_sec1 = i_sample;
                        default: n_sec2 = i_sample;
                    endcase
                end
                if (rise_next >= i_rises_needed) begin
                    n_rise = '0;
                    if (r_phase == PH_SEC2) begin
                        n_combo[CMB_S0S1] = CW'(n_sec1) + CW'(n_sec0);
                        n_combo[CMB_S0S2] = CW'(n_sec2) + CW'(n_sec0);
                        n_combo[CMB_S1S2] = CW'(n_sec2) + CW'(n_sec1);
                        n_combo[CMB_ALL]  = CW'(n_sec2) + CW'(n_sec1) + CW'(n_sec0);
                        n_phase = PH_RUN;
                    end else begin
                        n_phase = r_phase + PHASE_BITS'(1);
                    end
                end else begin
                    n_rise = rise_next;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_RUN;
            r_rise  <= '0;
            r_sec0  <= '0;
            r_sec1  <= '0;
            r_sec2  <= '0;
            r_combo <= '0;
        end else begin
            r_phase <= n_phase;
            r_rise  <= n_rise;
            r_sec0  <= n_sec0;
            r_sec1  <= n_sec1;
            r_sec2  <= n_sec2;
            r_combo <= n_combo;
        end
    end

    assign o_phase      = r_phase;
    assign o_next_phase = n_phase;
    assign o_sec0       = r_sec0;
    assign o_sec1       = r_sec1;
    assign o_sec2       = r_sec2;
    assign o_combo      = r_combo;

endmodule

`default_nettype wire

@@ sv/bend_sensor_calibrate_classify.sv @@
// Top level: input register, calibration/classification, result register.
//
// One item per clock cycle, sustained while the output side is not stalled.
// An accepted item sits in the input register until the result register can
// take it, is then processed against the calibration state and lands in the
// result register. The calibration state updates when an item moves from the
// input register to the result register, so each item sees the limits and
// phase that the previous item left. The rises_needed register resets to 20
// and is written through i_cfg_we/i_cfg_data; the user must write it only
// while the block is idle, as the block itself does not enforce this.
`default_nettype none

module bend_sensor_calibrate_classify
    import bscc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [RISE_BITS-1:0]    i_cfg_data,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic                    i_func,
    input  wire logic [SAMPLE_BITS-1:0]  i_sample,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic      [CODE_BITS-1:0]    o_bend_code,
    output logic      [PHASE_BITS-1:0]   o_cal_phase
);

    logic [RISE_BITS-1:0]            r_rises_needed;
    logic                            r_in_valid;
    logic                            r_in_func;
    logic [SAMPLE_BITS-1:0]          r_in_sample;
    logic                            r_out_valid;
    logic [CODE_BITS-1:0]            r_bend_code;
    logic [PHASE_BITS-1:0]           r_cal_phase;

    logic                            step;
    logic [PHASE_BITS-1:0]           phase, next_phase;
    logic [SAMPLE_BITS-1:0]          sec0, sec1, sec2;
    logic [3:0][SAMPLE_BITS+1:0]     combo;
    logic [CODE_BITS-1:0]            class_code;
    logic [CODE_BITS-1:0]            n_bend_code;

    assign step    = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rises_needed <= RISES_RESET;
        end else if (i_cfg_we) begin
            r_rises_needed <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_func   <= i_func;
            r_in_sample <= i_sample;
        end
    end

    bscc_calib #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_calib (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_func         (r_in_func),
        .i_sample       (r_in_sample),
        .i_rises_needed (r_rises_needed),
        .o_phase        (phase),
        .o_next_phase   (next_phase),
        .o_sec0         (sec0),
        .o_sec1         (sec1),
        .o_sec2         (sec2),
        .o_combo        (combo)
    );

    bscc_classify #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_classify (
        .i_sample (r_in_sample),
        .i_sec0   (sec0),
        .i_sec1   (sec1),
        .i_sec2   (sec2),
        .i_combo  (combo),
        .o_code   (class_code)
    );

    // start items and items taken during calibration answer "calibrating"
    assign n_bend_code = (r_in_func == FUNC_START || phase != PH_RUN) ?
                         BEND_CALIB : class_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_bend_code <= n_bend_code;
            r_cal_phase <= next_phase;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_bend_code = r_bend_code;
    assign o_cal_phase = r_cal_phase;

endmodule

`default_nettype wire

@@ sv/bscc_checker.sv @@
// Port-level checks for the bend sensor calibrate/classify block.
`default_nettype none

module bscc_checker
    import bscc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    input  wire logic                    o_ready,
    input  wire logic [SAMPLE_BITS-1:0]  i_sample,
    input  wire logic                    o_valid,
    input  wire logic                    i_ready,
    input  wire logic [CODE_BITS-1:0]    o_bend_code,
    input  wire logic [PHASE_BITS-1:0]   o_cal_phase
);

    // a waiting input item holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_ready) |=> (i_valid && $stable(i_sample)))
        else $error("input item changed while waiting");

    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_bend_code) &&
                                   $stable(o_cal_phase)))
        else $error("result item changed while stalled");

    // any item that leaves the block calibrating reports calibrating
    a_cal_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_cal_phase != PH_RUN) |-> (o_bend_code == BEND_CALIB))
        else $error("calibration phase without calibrating code");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_bend_code <= BEND_CALIB))
        else $error("bend code out of range");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && o_ready))
        else $error("block not empty after reset");

endmodule

bind bend_sensor_calibrate_classify bscc_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_bscc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .i_sample    (i_sample),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_bend_code (o_bend_code),
    .o_cal_phase (o_cal_phase)
);

`default_nettype wire
